// ===== hw/rtl/iconv3_pkg.sv =====
// Shared types and constants of the 3x3 image convolution block.
`timescale 1ns / 1ps
`default_nettype none

package iconv3_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int PIX_W       = 8;
  localparam int COEF_W      = 16;
  localparam int CFG_W       = 48;
  localparam int SIZE_W      = 9;
  localparam int CFG_ADDR_W  = 3;

  // Accumulated weighted sum, weight sum and their magnitudes.
  localparam int ACC_W       = 28;
  localparam int WSUM_W      = 20;
  localparam int NUM_MAG_W   = 27;
  localparam int DEN_MAG_W   = 19;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

  // Operation codes carried on s_tuser.
  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_TOP    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_MIDDLE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_BOTTOM = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_GRAY_MODE   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RESULT
  } iconv3_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  num;
    logic signed [WSUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PIX_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iconv3_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module iconv3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iconv3_div.sv =====
// Serial divider: weighted sum over weight sum, truncated and saturated to a pixel.
`timescale 1ns / 1ps
`default_nettype none

module iconv3_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire iconv3_pkg::div_req_t req,
  output iconv3_pkg::div_rsp_t      rsp
);

  import iconv3_pkg::*;

  logic                 busy;
  logic                 done;
  logic [3:0]           step;
  logic                 trivial;
  logic [NUM_MAG_W-1:0] rem;
  logic [NUM_MAG_W-1:0] dsh;
  logic [PIX_W-1:0]     quot;

  logic                 num_neg;
  logic                 den_neg;
  logic                 den_zero;
  logic [NUM_MAG_W-1:0] num_mag;
  logic [DEN_MAG_W-1:0] den_mag;
  logic                 ge;
  logic [NUM_MAG_W-1:0] diff;
  logic                 last_step;

  assign num_neg  = req.num[ACC_W-1];
  assign den_neg  = req.den[WSUM_W-1];
  assign den_zero = (req.den == '0);
  assign num_mag  = num_neg ? NUM_MAG_W'(-req.num) : NUM_MAG_W'(req.num);

  // A zero weight sum divides by 256, the scale of one Q8.8 unit.
  always_comb begin
    if (den_zero) begin
      den_mag = DEN_MAG_W'(256);
    end else if (den_neg) begin
      den_mag = DEN_MAG_W'(-req.den);
    end else begin
      den_mag = DEN_MAG_W'(req.den);
    end
  end

  assign ge        = (rem >= dsh);
  assign diff      = rem - dsh;
  assign last_step = (step == 4'(PIX_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (trivial) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (step == '0) begin
          if (ge) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            step <= step + 4'd1;
          end
        end else if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 4'd1;
        end
      end
    end
  end

  // The first busy cycle ends a trivial division or checks for a quotient above 255;
  // if neither holds, eight restoring steps follow, one quotient bit each.
  always_ff @(posedge clk) begin
    if (req.start) begin
      // A zero or negative quotient clamps to zero.
      trivial <= (req.num == '0) || (num_neg != (den_neg && !den_zero));
      rem     <= num_mag;
      dsh     <= {den_mag, {PIX_W{1'b0}}};
      quot    <= PIX_MIN;
    end else if (busy) begin
      if (trivial) begin
        quot <= PIX_MIN;
      end else if (step == '0) begin
        if (ge) begin
          quot <= PIX_MAX;
        end
        dsh <= dsh >> 1;
      end else begin
        if (ge) begin
          rem <= diff;
        end
        quot <= {quot[PIX_W-2:0], ge};
        dsh  <= dsh >> 1;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

// ===== hw/rtl/image_convolution_3x3.sv =====
// Top level of the 3x3 convolution: frame store, tap sequencer, MAC lanes and output register.
// A store word is written at the edge that accepts it; the block is ready again next cycle.
// A compute word steps through nine frame reads (ST_FETCH), a drain state, the serial divider
// per channel (three channels in color mode, one in gray) and a result state.
// A compute outside the configured frame goes from its accept straight to its result state.
// No new word is taken until a compute's result has been loaded into the output register.
// rst is synchronous: coefficients return to the identity mask, size to 256x256, color mode.
`timescale 1ns / 1ps
`default_nettype none

module image_convolution_3x3 #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // col [7:0], row [15:8], red_in [23:16], green_in [31:24], blue_in [39:32]
  input  wire logic [39:0]                  s_tdata,
  // operation
  input  wire logic                         s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic      [23:0]                  m_tdata,
  // out_of_range
  output logic                              m_tuser,
  input  wire logic                         cfg_we,
  input  wire logic [iconv3_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [iconv3_pkg::CFG_W-1:0]      cfg_data
);

  import iconv3_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;

  // Configuration registers.
  logic [CFG_W-1:0]  coef_top;
  logic [CFG_W-1:0]  coef_middle;
  logic [CFG_W-1:0]  coef_bottom;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic              gray_mode;

  iconv3_state_t state, state_next;

  logic [PIX_W-1:0]         col_q;
  logic [PIX_W-1:0]         row_q;
  logic                     oor_q;
  logic [1:0]               r_cnt;
  logic [1:0]               c_cnt;
  logic [1:0]               ch;
  logic                     mac_en;
  logic signed [COEF_W-1:0] w_q;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_g;
  logic signed [ACC_W-1:0]  acc_b;
  logic signed [WSUM_W-1:0] wsum;
  logic [PIX_W-1:0]         res_r;
  logic [PIX_W-1:0]         res_g;
  logic [PIX_W-1:0]         res_b;

  logic [9:0]               eff_w;
  logic [9:0]               eff_h;
  logic [PIX_W-1:0]         in_col;
  logic [PIX_W-1:0]         in_row;
  logic                     in_oor;
  logic                     in_store_ok;
  logic                     accept;
  logic                     last_tap;
  logic                     out_free;
  logic                     last_ch;

  logic [CFG_W-1:0]         coef_sel;
  logic signed [COEF_W-1:0] w_cur;
  logic [8:0]               nx;
  logic [8:0]               ny;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [3*PIX_W-1:0]       ram_rdata;

  logic signed [COEF_W+PIX_W:0] prod_r;
  logic signed [COEF_W+PIX_W:0] prod_g;
  logic signed [COEF_W+PIX_W:0] prod_b;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_start;
  logic     load_out;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top     <= '0;
      coef_middle  <= 48'h0000_0100_0000;
      coef_bottom  <= '0;
      image_width  <= 9'd256;
      image_height <= 9'd256;
      gray_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEF_TOP:     coef_top     <= cfg_data;
        REG_COEF_MIDDLE:  coef_middle  <= cfg_data;
        REG_COEF_BOTTOM:  coef_bottom  <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[SIZE_W-1:0];
        REG_GRAY_MODE:    gray_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one, a size beyond the store as the store size.
  always_comb begin
    if (image_width == '0) begin
      eff_w = 10'd1;
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = 10'(MAX_WIDTH);
    end else begin
      eff_w = {1'b0, image_width};
    end
    if (image_height == '0) begin
      eff_h = 10'd1;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = 10'(MAX_HEIGHT);
    end else begin
      eff_h = {1'b0, image_height};
    end
  end

  // ---------------------------------------------------------------- input decode
  assign in_col      = s_tdata[7:0];
  assign in_row      = s_tdata[15:8];
  assign in_oor      = ({2'b00, in_col} >= eff_w) || ({2'b00, in_row} >= eff_h);
  assign in_store_ok = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
  assign accept      = s_tvalid && s_tready;

  assign ram_we    = accept && (s_tuser == OP_STORE) && in_store_ok;
  assign ram_waddr = {YW'(in_row), XW'(in_col)};

  // ---------------------------------------------------------------- tap addressing
  // Neighbors outside the frame repeat the edge pixel.
  always_comb begin
    case (c_cnt)
      2'd0:    nx = (col_q == '0) ? 9'd0 : {1'b0, col_q} - 9'd1;
      2'd1:    nx = {1'b0, col_q};
      default: nx = (({2'b00, col_q} + 10'd1) >= eff_w) ? {1'b0, col_q}
                                                        : {1'b0, col_q} + 9'd1;
    endcase
    case (r_cnt)
      2'd0:    ny = (row_q == '0) ? 9'd0 : {1'b0, row_q} - 9'd1;
      2'd1:    ny = {1'b0, row_q};
      default: ny = (({2'b00, row_q} + 10'd1) >= eff_h) ? {1'b0, row_q}
                                                        : {1'b0, row_q} + 9'd1;
    endcase
  end

  assign ram_raddr = {YW'(ny), XW'(nx)};

  always_comb begin
    case (r_cnt)
      2'd0:    coef_sel = coef_top;
      2'd1:    coef_sel = coef_middle;
      default: coef_sel = coef_bottom;
    endcase
  end

  assign w_cur    = coef_sel[{c_cnt, 4'b0000} +: COEF_W];
  assign last_tap = (r_cnt == 2'd2) && (c_cnt == 2'd2);

  iconv3_ram #(
    .WIDTH (3 * PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata[39:16]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- MAC lanes
  assign prod_r = w_q * $signed({1'b0, ram_rdata[7:0]});
  assign prod_g = w_q * $signed({1'b0, ram_rdata[15:8]});
  assign prod_b = w_q * $signed({1'b0, ram_rdata[23:16]});

  // ---------------------------------------------------------------- divider
  assign last_ch = gray_mode || (ch == 2'd2);

  always_comb begin
    div_req.start = div_start;
    div_req.den   = wsum;
    case (ch)
      2'd0:    div_req.num = acc_r;
      2'd1:    div_req.num = acc_g;
      default: div_req.num = acc_b;
    endcase
  end

  iconv3_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && (s_tuser == OP_COMPUTE)) begin
          state_next = in_oor ? ST_RESULT : ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:     state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = last_ch ? ST_RESULT : ST_DIV_START;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:      s_tready  = !rst;
      ST_FETCH:     ram_re    = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_RESULT:    load_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mac_en   <= 1'b0;
      r_cnt    <= '0;
      c_cnt    <= '0;
      ch       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      mac_en <= ram_re;
      if (accept) begin
        r_cnt <= '0;
        c_cnt <= '0;
        ch    <= '0;
      end else if (ram_re) begin
        if (c_cnt == 2'd2) begin
          c_cnt <= '0;
          r_cnt <= r_cnt + 2'd1;
        end else begin
          c_cnt <= c_cnt + 2'd1;
        end
      end else if ((state == ST_DIV_WAIT) && div_rsp.done) begin
        ch <= ch + 2'd1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= in_col;
      row_q <= in_row;
      oor_q <= in_oor;
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
      wsum  <= '0;
    end else if (mac_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
      acc_g <= acc_g + ACC_W'(prod_g);
      acc_b <= acc_b + ACC_W'(prod_b);
      wsum  <= wsum + WSUM_W'(w_q);
    end
    w_q <= w_cur;
    if ((state == ST_DIV_WAIT) && div_rsp.done) begin
      case (ch)
        2'd0:    res_r <= div_rsp.quot;
        2'd1:    res_g <= div_rsp.quot;
        default: res_b <= div_rsp.quot;
      endcase
    end
    if (load_out) begin
      m_tuser <= oor_q;
      if (oor_q) begin
        m_tdata <= {PIX_MIN, PIX_MIN, PIX_MIN};
      end else if (gray_mode) begin
        m_tdata <= {res_r, res_r, res_r};
      end else begin
        m_tdata <= {res_b, res_g, res_r};
      end
    end
  end

  // ---------------------------------------------------------------- assertions
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while still busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_WAIT))
    else $error("divider result arrived outside the wait state");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("out-of-range result carries nonzero pixel data");

  a_gray_copy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && gray_mode) |->
      ((m_tdata[15:8] == m_tdata[7:0]) && (m_tdata[23:16] == m_tdata[7:0])))
    else $error("gray mode result not replicated to all channels");

  a_fetch_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(ram_re) |-> ($past(accept) && (r_cnt == 2'd0) && (c_cnt == 2'd0)))
    else $error("tap fetch began without a fresh compute word");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the 3x3 convolution block: a directed table, then random phases.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import iconv3_pkg::*;

  localparam int ITEM_TARGET   = 1100;
  localparam int SETTLE_CYCLES = 50;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 600;
  localparam int FRAME_DIM     = 256;

  // Indexes with no register behind them.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  // Pixels of the directed part, blue in the top byte and red in the low byte.
  localparam logic [23:0] PX_ORIGIN = 24'h5AFF00;
  localparam logic [23:0] PX_RIGHT  = 24'hA500FF;
  localparam logic [23:0] PX_BELOW  = 24'h563412;
  localparam logic [23:0] PX_DIAG   = 24'hFFFFFF;
  localparam logic [23:0] PX_FAR    = 24'h3C81F0;

  typedef enum int {K_RANDOM, K_BLUR, K_EXTREME, K_EDGE} kernel_kind_t;

  typedef struct packed {
    logic       oor;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_res_t;

  typedef struct packed {
    logic                  is_reg;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_W-1:0]      reg_val;
    logic                  op;
    logic [7:0]            col;
    logic [7:0]            row;
    logic [23:0]           pix;
    logic                  known;
    pixel_res_t            res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [39:0]           s_tdata = '0;
  logic                  s_tuser = OP_STORE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_COEF_TOP;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Shadow of the frame store and the registers.
  logic [23:0]       pix_mem [FRAME_DIM*FRAME_DIM];
  bit                written [FRAME_DIM*FRAME_DIM];
  logic [CFG_W-1:0]  coef_sh [3] = '{48'h0, 48'h000001000000, 48'h0};
  logic [SIZE_W-1:0] width_sh = 9'd256;
  logic [SIZE_W-1:0] height_sh = 9'd256;
  logic              gray_sh = 1'b0;

  pixel_res_t filtered_q [$];
  int         mismatches = 0;
  int         words_in = 0;
  int         quiet_cycles = 0;
  bit         no_idle = 1'b0;
  bit         rx_hold_req = 1'b0;

  image_convolution_3x3 u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int eff_dim(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    return (int'(v) > FRAME_DIM) ? FRAME_DIM : int'(v);
  endfunction

  function automatic int edge_clamp(input int v, input int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  function automatic int tap_weight(input int r, input int c);
    logic signed [COEF_W-1:0] raw;
    raw = coef_sh[r][COEF_W*c +: COEF_W];
    return int'(raw);
  endfunction

  function automatic pixel_res_t filter_pixel(input logic [7:0] col, input logic [7:0] row);
    pixel_res_t res;
    int         w, h, wsum, acc, v, x, y;
    logic [7:0] chan [3];
    w = eff_dim(width_sh);
    h = eff_dim(height_sh);
    res = '0;
    if (int'(col) >= w || int'(row) >= h) begin
      res.oor = 1'b1;
      return res;
    end
    wsum = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        wsum += tap_weight(r, c);
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        y = edge_clamp(int'(row) + r - 1, h);
        for (int c = 0; c < 3; c++) begin
          x = edge_clamp(int'(col) + c - 1, w);
          acc += tap_weight(r, c) * int'(pix_mem[y*FRAME_DIM + x][8*ch +: 8]);
        end
      end
      // Signed division truncates toward zero; a zero weight sum falls back to the Q8.8 scale.
      v = (wsum != 0) ? acc / wsum : acc / 256;
      if (v > int'(PIX_MAX)) chan[ch] = PIX_MAX;
      else if (v < int'(PIX_MIN)) chan[ch] = PIX_MIN;
      else chan[ch] = v[7:0];
    end
    res.red = chan[0];
    res.green = gray_sh ? chan[0] : chan[1];
    res.blue = gray_sh ? chan[0] : chan[2];
    return res;
  endfunction

  function automatic dir_row_t dir_store(input logic [7:0] col, input logic [7:0] row,
                                         input logic [23:0] pix);
    dir_row_t d;
    d = '0;
    d.op = OP_STORE;
    d.col = col;
    d.row = row;
    d.pix = pix;
    return d;
  endfunction

  function automatic dir_row_t dir_compute(input logic [7:0] col, input logic [7:0] row);
    dir_row_t d;
    d = '0;
    d.op = OP_COMPUTE;
    d.col = col;
    d.row = row;
    return d;
  endfunction

  function automatic dir_row_t dir_expect(input logic [7:0] col, input logic [7:0] row,
                                          input logic oor, input logic [23:0] bgr);
    dir_row_t d;
    d = dir_compute(col, row);
    d.known = 1'b1;
    d.res = {oor, bgr};
    return d;
  endfunction

  function automatic dir_row_t dir_reg(input logic [CFG_ADDR_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    dir_row_t d;
    d = '0;
    d.is_reg = 1'b1;
    d.reg_idx = idx;
    d.reg_val = val;
    return d;
  endfunction

  function automatic logic [CFG_W-1:0] random_coef_row(input kernel_kind_t kind, input int r);
    logic [CFG_W-1:0] row_v;
    row_v = '0;
    case (kind)
      K_RANDOM: row_v = CFG_W'({$urandom(), $urandom()});
      K_BLUR: begin
        for (int c = 0; c < 3; c++) row_v[COEF_W*c +: COEF_W] = 16'($urandom_range(0, 1024));
      end
      K_EXTREME: begin
        for (int c = 0; c < 3; c++)
          case ($urandom_range(0, 4))
            0: row_v[COEF_W*c +: COEF_W] = 16'h7FFF;
            1: row_v[COEF_W*c +: COEF_W] = 16'h8000;
            2: row_v[COEF_W*c +: COEF_W] = 16'h0000;
            3: row_v[COEF_W*c +: COEF_W] = 16'hFFFF;
            default: row_v[COEF_W*c +: COEF_W] = 16'h0100;
          endcase
      end
      default: row_v = (r == 1) ? 48'hFF00_0400_FF00 : 48'h0000_FF00_0000;
    endcase
    return row_v;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Offers one word and updates the shadow once the block takes it.
  task automatic send_word(input logic op, input logic [7:0] col, input logic [7:0] row,
                           input logic [23:0] pix, input bit known, input pixel_res_t res);
    int gap;
    int idx;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    idx = int'(row) * FRAME_DIM + int'(col);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {pix, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_in++;
    if (op == OP_STORE) begin
      pix_mem[idx] = pix;
      written[idx] = 1'b1;
    end else begin
      filtered_q.push_back(known ? res : filter_pixel(col, row));
    end
  endtask

  // Stores any pixel of the clamped window not yet written, then asks for the filtered pixel.
  task automatic send_compute(input logic [7:0] col, input logic [7:0] row);
    int w, h, x, y;
    w = eff_dim(width_sh);
    h = eff_dim(height_sh);
    if (int'(col) < w && int'(row) < h) begin
      for (int r = -1; r <= 1; r++)
        for (int c = -1; c <= 1; c++) begin
          x = edge_clamp(int'(col) + c, w);
          y = edge_clamp(int'(row) + r, h);
          if (!written[y*FRAME_DIM + x])
            send_word(OP_STORE, x[7:0], y[7:0], 24'($urandom()), 1'b0, '0);
        end
    end
    send_word(OP_COMPUTE, col, row, 24'($urandom()), 1'b0, '0);
  endtask

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEF_TOP:     coef_sh[0] = val;
      REG_COEF_MIDDLE:  coef_sh[1] = val;
      REG_COEF_BOTTOM:  coef_sh[2] = val;
      REG_IMAGE_WIDTH:  width_sh = val[SIZE_W-1:0];
      REG_IMAGE_HEIGHT: height_sh = val[SIZE_W-1:0];
      REG_GRAY_MODE:    gray_sh = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_setup();
    kernel_kind_t      kind;
    logic [SIZE_W-1:0] dims [2];
    kind = kernel_kind_t'($urandom_range(0, 3));
    for (int d = 0; d < 2; d++)
      case ($urandom_range(0, 9))
        0: dims[d] = '0;
        1: dims[d] = SIZE_W'($urandom_range(256, 511));
        2: dims[d] = SIZE_W'($urandom_range(1, 255));
        default: dims[d] = SIZE_W'($urandom_range(1, 8));
      endcase
    program_reg(REG_COEF_TOP, random_coef_row(kind, 0));
    program_reg(REG_COEF_MIDDLE, random_coef_row(kind, 1));
    program_reg(REG_COEF_BOTTOM, random_coef_row(kind, 2));
    program_reg(REG_IMAGE_WIDTH, CFG_W'(dims[0]));
    program_reg(REG_IMAGE_HEIGHT, CFG_W'(dims[1]));
    program_reg(REG_GRAY_MODE, CFG_W'($urandom_range(0, 1)));
  endtask

  // Result side: random stalls, one long hold-off on request, none in a no-idle phase.
  initial begin
    int stall;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pixel_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, got data %h oor %b",
                 $time, m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = filtered_q.pop_front();
        check_field("red_out", want.red, m_tdata[7:0]);
        check_field("green_out", want.green, m_tdata[15:8]);
        check_field("blue_out", want.blue, m_tdata[23:16]);
        check_field("out_of_range", {7'b0, want.oor}, {7'b0, m_tuser});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL image_convolution_3x3");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    int       phase, n, w, h, pick;
    dir_tab = '{
      dir_store(8'd0, 8'd0, PX_ORIGIN),
      dir_store(8'd1, 8'd0, PX_RIGHT),
      dir_store(8'd0, 8'd1, PX_BELOW),
      dir_store(8'd1, 8'd1, PX_DIAG),
      // Identity mask after reset: the corners (0,0) and (255,255) each return their own pixel.
      dir_expect(8'd0, 8'd0, 1'b0, PX_ORIGIN),
      dir_store(8'd254, 8'd254, 24'h010203),
      dir_store(8'd255, 8'd254, 24'hFE7F80),
      dir_store(8'd254, 8'd255, 24'h00FF7E),
      dir_store(8'd255, 8'd255, PX_FAR),
      dir_expect(8'd255, 8'd255, 1'b0, PX_FAR),
      dir_reg(REG_IMAGE_WIDTH, 48'd2),
      dir_reg(REG_IMAGE_HEIGHT, 48'd2),
      dir_expect(8'd1, 8'd1, 1'b0, PX_DIAG),
      dir_expect(8'd2, 8'd0, 1'b1, 24'h0),
      dir_expect(8'd0, 8'd2, 1'b1, 24'h0),
      dir_expect(8'd255, 8'd255, 1'b1, 24'h0),
      // A size of zero behaves as a single pixel.
      dir_reg(REG_IMAGE_WIDTH, 48'd0),
      dir_reg(REG_IMAGE_HEIGHT, 48'd0),
      dir_expect(8'd0, 8'd0, 1'b0, PX_ORIGIN),
      dir_expect(8'd1, 8'd0, 1'b1, 24'h0),
      dir_expect(8'd0, 8'd1, 1'b1, 24'h0),
      // Sizes beyond the store are cut down to it.
      dir_reg(REG_IMAGE_WIDTH, 48'd511),
      dir_reg(REG_IMAGE_HEIGHT, 48'd300),
      dir_expect(8'd255, 8'd255, 1'b0, PX_FAR),
      dir_reg(REG_GRAY_MODE, 48'd1),
      dir_expect(8'd255, 8'd255, 1'b0, 24'hF0F0F0),
      // With every weight zero the sum is scaled by 256 instead of the weight sum.
      dir_reg(REG_COEF_MIDDLE, 48'd0),
      dir_expect(8'd255, 8'd255, 1'b0, 24'h0),
      dir_reg(REG_GRAY_MODE, 48'd0),
      dir_reg(REG_COEF_TOP, 48'h8000_8000_8000),
      dir_reg(REG_COEF_MIDDLE, 48'h7FFF_7FFF_7FFF),
      dir_reg(REG_COEF_BOTTOM, 48'hFFFF_0100_FF00),
      dir_compute(8'd0, 8'd0),
      dir_compute(8'd255, 8'd255),
      dir_reg(REG_SPARE_LO, 48'hFFFF_FFFF_FFFF),
      dir_reg(REG_SPARE_HI, 48'h1234_5678_9ABC),
      dir_compute(8'd0, 8'd0),
      dir_reg(REG_COEF_MIDDLE, 48'hFF00_0400_FF00),
      dir_compute(8'd255, 8'd255)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        wait_until_drained();
        program_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_word(dir_tab[i].op, dir_tab[i].col, dir_tab[i].row, dir_tab[i].pix,
                  dir_tab[i].known, dir_tab[i].res);
      end
    end

    // The first phase holds the result side off so the block backs up its input;
    // the second runs with no gaps on either side.
    phase = 0;
    while (words_in < ITEM_TARGET) begin
      wait_until_drained();
      random_setup();
      no_idle = (phase == 1);
      if (phase == 0) rx_hold_req = 1'b1;
      n = $urandom_range(60, 140);
      for (int i = 0; (i < n) && (words_in < ITEM_TARGET); i++) begin
        w = eff_dim(width_sh);
        h = eff_dim(height_sh);
        pick = $urandom_range(0, 99);
        if (pick < 10)
          send_word(OP_STORE, 8'($urandom()), 8'($urandom()), 24'($urandom()), 1'b0, '0);
        else if (pick < 45)
          send_word(OP_STORE, 8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
                    24'($urandom()), 1'b0, '0);
        else if (pick < 90)
          send_compute(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)));
        else if (pick < 98)
          send_compute(8'($urandom()), 8'($urandom()));
        else
          wait_until_drained();
      end
      phase++;
    end
    no_idle = 1'b0;

    wait_until_drained();
    if (mismatches == 0) $display("PASS image_convolution_3x3");
    else $display("FAIL image_convolution_3x3");
    $finish;
  end

endmodule

`default_nettype wire
